// ----- rtl/sms_pkg.sv -----
// shared types and constants of the markup splitter
`default_nettype none

package sms_pkg;

	localparam int CHAR_W          = 8;
	localparam int CODE_W          = 16;
	localparam int MAX_RES         = 3;
	localparam int CNT_W           = 2;
	localparam int VALUE_WIDTH_DEF = 16;

	// byte codes the lexer reacts to
	localparam logic [CHAR_W-1:0] CH_LT   = 8'h3C;
	localparam logic [CHAR_W-1:0] CH_GT   = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1    = 8'h31;
	localparam logic [CHAR_W-1:0] CH_7    = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
	localparam logic [CHAR_W-1:0] CH_F_LO = 8'h66;
	localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
	localparam logic [CHAR_W-1:0] CH_F_UP = 8'h46;
	localparam logic [CHAR_W-1:0] CH_X_LO = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UP = 8'h58;

	typedef enum logic [2:0] {
		EV_TEXT = 3'd0,
		EV_TBEG = 3'd1,
		EV_TCHR = 3'd2,
		EV_TEND = 3'd3,
		EV_CBEG = 3'd4,
		EV_CCHR = 3'd5,
		EV_CEND = 3'd6
	} event_t;

	typedef struct packed {
		event_t              ev;
		logic [CODE_W-1:0]   code;
	} res_t;

	// all results caused by one request, res[0] goes out first
	typedef struct packed {
		logic [CNT_W-1:0]      cnt;
		res_t [MAX_RES-1:0]    res;
	} bundle_t;

endpackage

`default_nettype wire

// ----- rtl/sgml_markup_splitter.sv -----
// top level of the markup splitter: byte lexer followed by result drain
// path: a byte goes first into the input register and then, once the drain is free, its first
// result is loaded into the result register, from which it is offered
// throughput: one byte per cycle while each byte gives at most one result and out_stall
// stays low; a byte that gives more results holds the drain register until the result port has taken them all
// reset: arst_n clears the lexer to the text state, the accumulator to zero and
// empties the input and result registers
`default_nettype none

module sgml_markup_splitter #(
	parameter int VALUE_WIDTH = sms_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// byte request channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [sms_pkg::CHAR_W-1:0]  char_in,
	// result request channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       event_res,
	output logic [sms_pkg::CODE_W-1:0]       code,
	output logic                             last
);

	// bundle of up to three results made by one byte
	sms_pkg::bundle_t  bundle;
	// the drain can take a new bundle at this edge
	logic              free;
	// lexer advances and the byte produced at least one result
	logic              load;

	// stage one: input register, state machine and saturating accumulator;
	// the byte is stalled only while the drain still holds earlier results
	sms_parser #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.char_in  (char_in),
		.free     (free),
		.load     (load),
		.bundle   (bundle)
	);

	// stage two: result register, serializes the bundle in order and flags
	// the final result of each byte
	sms_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.code      (code),
		.last      (last)
	);

endmodule

`default_nettype wire

// ----- rtl/sms_parser.sv -----
// input register and lexer state machine, one request per cycle while the drain is free
`default_nettype none

module sms_parser #(
	parameter int VALUE_WIDTH = sms_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [sms_pkg::CHAR_W-1:0]  char_in,
	input  wire logic                        free,
	output logic                             load,
	output sms_pkg::bundle_t                 bundle
);

	localparam int AW = VALUE_WIDTH + 4;
	localparam logic [VALUE_WIDTH-1:0] VMAX = {VALUE_WIDTH{1'b1}};

	typedef enum logic [3:0] {
		ST_TEXT    = 4'd0,
		ST_OPEN    = 4'd1,
		ST_ZERO    = 4'd2,
		ST_HEX     = 4'd3,
		ST_DEC     = 4'd4,
		ST_OCT     = 4'd5,
		ST_TAG     = 4'd6,
		ST_DASH1   = 4'd7,
		ST_COM     = 4'd8,
		ST_COMDASH = 4'd9
	} state_t;

	state_t                         state_q, state_d;
	logic [VALUE_WIDTH-1:0]         num_q, num_d;
	logic [sms_pkg::CHAR_W-1:0]     char_s1;
	logic                           valid_s1;
	logic                           adv;

	logic [sms_pkg::CHAR_W-1:0]     ch;
	logic [sms_pkg::CODE_W-1:0]     ch_code;
	logic [sms_pkg::CODE_W-1:0]     num_code;
	logic [VALUE_WIDTH+sms_pkg::CODE_W-1:0] num_ext;
	logic                           is_dec, is_oct, is_hex_lt;
	logic [3:0]                     dig;
	logic                           dig_ok;
	logic [AW-1:0]                  num_w, prod, acc;
	logic [VALUE_WIDTH-1:0]         acc_sat;
	sms_pkg::res_t                  r0, r1, r2;
	logic [sms_pkg::CNT_W-1:0]      cnt;

	assign adv      = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= ST_TEXT;
			num_q    <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				state_q <= state_d;
				num_q   <= num_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
		end
	end

	assign ch       = char_s1;
	assign ch_code  = {{(sms_pkg::CODE_W-sms_pkg::CHAR_W){1'b0}}, ch};
	assign num_ext  = {{sms_pkg::CODE_W{1'b0}}, num_q};
	assign num_code = num_ext[sms_pkg::CODE_W-1:0];

	// digit decode and saturating multiply-add for the three radixes
	assign is_dec    = (ch >= sms_pkg::CH_0) && (ch <= sms_pkg::CH_9);
	assign is_oct    = (ch >= sms_pkg::CH_0) && (ch <= sms_pkg::CH_7);
	assign is_hex_lt = ((ch >= sms_pkg::CH_A_LO) && (ch <= sms_pkg::CH_F_LO)) ||
	                   ((ch >= sms_pkg::CH_A_UP) && (ch <= sms_pkg::CH_F_UP));
	assign dig       = is_dec ? ch[3:0] : ch[3:0] + 4'd9;
	assign num_w     = {4'b0, num_q};

	always_comb begin
		unique case (state_q) inside
			ST_HEX: begin
				dig_ok = is_dec || is_hex_lt;
				prod   = num_w << 4;
			end
			ST_OCT: begin
				dig_ok = is_oct;
				prod   = num_w << 3;
			end
			default: begin
				dig_ok = is_dec;
				prod   = (num_w << 3) + (num_w << 1);
			end
		endcase
		acc     = prod + {{(AW-4){1'b0}}, dig};
		acc_sat = (acc > {4'b0, VMAX}) ? VMAX : acc[VALUE_WIDTH-1:0];
	end

	always_comb begin
		state_d = state_q;
		num_d   = num_q;
		cnt     = 2'd0;
		r0      = '{ev: sms_pkg::EV_TEXT, code: '0};
		r1      = '{ev: sms_pkg::EV_TEXT, code: '0};
		r2      = '{ev: sms_pkg::EV_TEXT, code: '0};
		unique case (state_q) inside
			ST_OPEN: begin
				num_d = '0;
				if (ch == sms_pkg::CH_0) begin
					state_d = ST_ZERO;
				end else if ((ch >= sms_pkg::CH_1) && (ch <= sms_pkg::CH_9)) begin
					num_d   = {{(VALUE_WIDTH-4){1'b0}}, ch[3:0]};
					state_d = ST_DEC;
				end else if (ch == sms_pkg::CH_DASH) begin
					state_d = ST_DASH1;
				end else if (ch == sms_pkg::CH_GT) begin
					state_d = ST_TEXT;
				end else begin
					r0      = '{ev: sms_pkg::EV_TBEG, code: '0};
					r1      = '{ev: sms_pkg::EV_TCHR, code: ch_code};
					cnt     = 2'd2;
					state_d = ST_TAG;
				end
			end
			ST_ZERO: begin
				if ((ch == sms_pkg::CH_X_LO) || (ch == sms_pkg::CH_X_UP)) begin
					state_d = ST_HEX;
				end else if (is_oct) begin
					num_d   = {{(VALUE_WIDTH-4){1'b0}}, ch[3:0]};
					state_d = ST_OCT;
				end else if (ch == sms_pkg::CH_GT) begin
					r0      = '{ev: sms_pkg::EV_TEXT, code: '0};
					cnt     = 2'd1;
					state_d = ST_TEXT;
				end else begin
					// zero then junk: the zero becomes a tag char
					r0      = '{ev: sms_pkg::EV_TBEG, code: '0};
					r1      = '{ev: sms_pkg::EV_TCHR,
					            code: {{(sms_pkg::CODE_W-sms_pkg::CHAR_W){1'b0}}, sms_pkg::CH_0}};
					cnt     = 2'd2;
					state_d = ST_TAG;
				end
			end
			ST_HEX, ST_DEC, ST_OCT: begin
				if (dig_ok) begin
					num_d = acc_sat;
				end else if (ch == sms_pkg::CH_GT) begin
					r0      = '{ev: sms_pkg::EV_TEXT, code: num_code};
					cnt     = 2'd1;
					state_d = ST_TEXT;
				end else begin
					// bad digit: partial value as tag char, byte dropped
					r0      = '{ev: sms_pkg::EV_TBEG, code: '0};
					r1      = '{ev: sms_pkg::EV_TCHR, code: num_code};
					cnt     = 2'd2;
					state_d = ST_TAG;
				end
			end
			ST_TAG: begin
				if (ch == sms_pkg::CH_GT) begin
					r0      = '{ev: sms_pkg::EV_TEND, code: '0};
					state_d = ST_TEXT;
				end else begin
					r0 = '{ev: sms_pkg::EV_TCHR, code: ch_code};
				end
				cnt = 2'd1;
			end
			ST_DASH1: begin
				if (ch == sms_pkg::CH_DASH) begin
					r0      = '{ev: sms_pkg::EV_CBEG, code: '0};
					cnt     = 2'd1;
					state_d = ST_COM;
				end else if (ch == sms_pkg::CH_GT) begin
					r0      = '{ev: sms_pkg::EV_TBEG, code: '0};
					r1      = '{ev: sms_pkg::EV_TCHR,
					            code: {{(sms_pkg::CODE_W-sms_pkg::CHAR_W){1'b0}}, sms_pkg::CH_DASH}};
					r2      = '{ev: sms_pkg::EV_TEND, code: '0};
					cnt     = 2'd3;
					state_d = ST_TEXT;
				end else begin
					r0      = '{ev: sms_pkg::EV_TBEG, code: '0};
					r1      = '{ev: sms_pkg::EV_TCHR,
					            code: {{(sms_pkg::CODE_W-sms_pkg::CHAR_W){1'b0}}, sms_pkg::CH_DASH}};
					r2      = '{ev: sms_pkg::EV_TCHR, code: ch_code};
					cnt     = 2'd3;
					state_d = ST_TAG;
				end
			end
			ST_COM: begin
				if (ch == sms_pkg::CH_DASH) begin
					state_d = ST_COMDASH;
				end else begin
					r0  = '{ev: sms_pkg::EV_CCHR, code: ch_code};
					cnt = 2'd1;
				end
			end
			ST_COMDASH: begin
				if (ch == sms_pkg::CH_DASH) begin
					r0      = '{ev: sms_pkg::EV_CEND, code: '0};
					cnt     = 2'd1;
					state_d = ST_OPEN;
				end else begin
					r0      = '{ev: sms_pkg::EV_CCHR,
					            code: {{(sms_pkg::CODE_W-sms_pkg::CHAR_W){1'b0}}, sms_pkg::CH_DASH}};
					r1      = '{ev: sms_pkg::EV_CCHR, code: ch_code};
					cnt     = 2'd2;
					state_d = ST_COM;
				end
			end
			default: begin
				if (ch == sms_pkg::CH_LT) begin
					state_d = ST_OPEN;
				end else begin
					r0  = '{ev: sms_pkg::EV_TEXT, code: ch_code};
					cnt = 2'd1;
				end
			end
		endcase
	end

	assign load       = adv && (cnt != 2'd0);
	assign bundle.cnt = cnt;
	assign bundle.res = {r2, r1, r0};

endmodule

`default_nettype wire

// ----- rtl/sms_drain.sv -----
// result register that hands out a bundle one result per cycle while out_stall is low
`default_nettype none

module sms_drain (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire sms_pkg::bundle_t            bundle,
	output logic                             free,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       event_res,
	output logic [sms_pkg::CODE_W-1:0]       code,
	output logic                             last
);

	logic [sms_pkg::CNT_W-1:0]   cnt_q;
	logic [sms_pkg::CNT_W-1:0]   idx_q;
	sms_pkg::bundle_t            bundle_q;
	sms_pkg::res_t               cur;
	logic                        take;

	assign out_valid = (cnt_q != 2'd0);
	assign last      = out_valid && (idx_q == cnt_q - 2'd1);
	assign take      = out_valid && !out_stall;
	assign free      = !out_valid || (take && last);

	always_comb begin
		case (idx_q)
			2'd0:    cur = bundle_q.res[0];
			2'd1:    cur = bundle_q.res[1];
			default: cur = bundle_q.res[2];
		endcase
	end

	assign event_res = cur.ev;
	assign code      = cur.code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

endmodule

`default_nettype wire
